### sv/ecr_pkg.sv
package ecr_pkg;

	// Echo lines carried by the input beat; channels above this never toggle.
	localparam int unsigned MAX_LANES = 4;
	localparam int unsigned OUT_DIST_W = 24;

	// Speed of sound in tenths of m/s: base + step * degrees C (rounding folded in).
	localparam logic signed [12:0] SPEED_BASE = 13'sd3315;
	localparam logic signed [12:0] SPEED_STEP = 13'sd6;
	localparam logic [11:0] SPEED_RESET = 12'd3435;

	// Reciprocals of 5, each exact over the range of its operand.
	// x[28:0] / 5 = (x * RECIP_A) >> 31
	localparam logic [28:0] RECIP_A = 29'd429496730;
	// x[17:0] / 5 = (x * RECIP_B) >> 20
	localparam logic [17:0] RECIP_B = 18'd209716;
	// x[20:0] / 5 = (x * RECIP_C) >> 23
	localparam logic [20:0] RECIP_C = 21'd1677722;

	typedef struct packed {
		logic [3:0]  echo_levels;
		logic [31:0] now_ticks;
	} in_beat_t;

	typedef struct packed {
		logic [23:0] distance_zero;
		logic [23:0] distance_one;
		logic [23:0] distance_two;
		logic [23:0] distance_three;
		logic [3:0]  updated_mask;
	} out_beat_t;

	typedef struct packed {
		logic                 valid;
		logic [MAX_LANES-1:0] fall;
	} front_ctl_t;

endpackage

### sv/multi_channel_echo_ranger.sv
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid / in_ready     | in_data: echo_levels, now_ticks
//  out     | output    | out_valid / out_ready   | out_data: four distances, updated_mask
//  cfg     | input     | cfg_we (no wait)        | cfg_wdata: air temperature, deg C
//
//  One beat in per clock unless the output stalls, one result beat out per input
//  beat. Throughput is set by the loop that compares each sample with the previous
//  line levels and stored rise times. A stalled output holds the whole pipeline;
//  in_ready drops only while a result waits unaccepted. Reset clears line levels,
//  rise times, distances and sets the temperature to 20 C.
module multi_channel_echo_ranger import ecr_pkg::*; #(
	parameter int unsigned NUM_SENSORS    = 4,
	parameter int unsigned DISTANCE_WIDTH = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_beat_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_beat_t         out_data,
	input  logic              cfg_we,
	input  logic signed [7:0] cfg_wdata
);

	// Lines above the fourth are never driven, so they never produce a distance.
	localparam int unsigned LANES = (NUM_SENSORS < MAX_LANES) ? NUM_SENSORS : MAX_LANES;

	logic                      en;
	logic signed [12:0]        speed_calc;
	logic [11:0]               speed_q;
	front_ctl_t                ctl_s2;
	logic [31:0]               width_s2 [LANES];
	logic                      v_s3;
	logic                      v_s4;
	logic                      v_s5;
	logic                      v_s6;
	logic [LANES-1:0]          fall_s5;
	logic [DISTANCE_WIDTH-1:0] dist_new [LANES];
	logic [DISTANCE_WIDTH-1:0] distance_q [LANES];
	logic [LANES-1:0]          mask_s6;
	logic [OUT_DIST_W-1:0]     dist_out [MAX_LANES];

	// Advance every stage together unless a finished result is stuck.
	assign en       = ~v_s6 | out_ready;
	assign in_ready = en;

	// Fold the temperature into a speed once, at write time.
	assign speed_calc = SPEED_BASE + SPEED_STEP * 13'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
		end else if (cfg_we) begin
			speed_q <= speed_calc[11:0];
		end
	end

	// Edge detection, rise times and pulse widths.
	ecr_front #(
		.LANES(LANES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.ctl_s2   (ctl_s2),
		.width_s2 (width_s2)
	);

	// One conversion lane per sensor: width to micrometres.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		ecr_lane #(
			.DIST_W(DISTANCE_WIDTH)
		) u_lane (
			.clk      (clk),
			.en       (en),
			.fall_in  (ctl_s2.fall[i]),
			.width_in (width_s2[i]),
			.speed    (speed_q),
			.fall_s5  (fall_s5[i]),
			.distance (dist_new[i])
		);
	end

	// Valid bits travel alongside the lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			mask_s6 <= '0;
		end else if (en) begin
			v_s3    <= ctl_s2.valid;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			mask_s6 <= fall_s5 & {LANES{v_s5}};
		end
	end

	// Latch the new distance of each channel that saw a falling edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				distance_q[i] <= '0;
			end
		end else if (en && v_s5) begin
			for (int i = 0; i < LANES; i++) begin
				if (fall_s5[i]) begin
					distance_q[i] <= dist_new[i];
				end
			end
		end
	end

	// Absent sensors report zero; wider distances truncate to the field.
	for (genvar j = 0; j < MAX_LANES; j++) begin : g_out
		if (j < LANES) begin : g_used
			assign dist_out[j] = OUT_DIST_W'(32'(distance_q[j]));
		end else begin : g_absent
			assign dist_out[j] = '0;
		end
	end

	assign out_valid               = v_s6;
	assign out_data.distance_zero  = dist_out[0];
	assign out_data.distance_one   = dist_out[1];
	assign out_data.distance_two   = dist_out[2];
	assign out_data.distance_three = dist_out[3];
	assign out_data.updated_mask   = 4'(mask_s6);

endmodule

### sv/ecr_front.sv
module ecr_front import ecr_pkg::*; #(
	parameter int unsigned LANES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  in_beat_t    in_data,
	output front_ctl_t  ctl_s2,
	output logic [31:0] width_s2 [LANES]
);

	logic              v_s1;
	logic [3:0]        levels_s1;
	logic [31:0]       now_s1;
	logic [LANES-1:0]  prev_q;
	logic [31:0]       rise_q [LANES];
	logic [LANES-1:0]  rise;
	logic [LANES-1:0]  fall;
	logic [31:0]       width [LANES];

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			levels_s1 <= in_data.echo_levels;
			now_s1    <= in_data.now_ticks;
		end
	end

	// Edge detect and pulse width against the stored rise time.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			rise[i]  = levels_s1[i] & ~prev_q[i];
			fall[i]  = ~levels_s1[i] & prev_q[i];
			width[i] = now_s1 - rise_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			for (int i = 0; i < LANES; i++) begin
				rise_q[i] <= '0;
			end
		end else if (en && v_s1) begin
			prev_q <= levels_s1[LANES-1:0];
			for (int i = 0; i < LANES; i++) begin
				if (rise[i]) begin
					rise_q[i] <= now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= v_s1;
			ctl_s2.fall  <= MAX_LANES'(fall & {LANES{v_s1}});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				width_s2[i] <= width[i];
			end
		end
	end

endmodule

### sv/ecr_lane.sv
module ecr_lane import ecr_pkg::*; #(
	parameter int unsigned DIST_W = 24
) (
	input  logic              clk,
	input  logic              en,
	input  logic              fall_in,
	input  logic [31:0]       width_in,
	input  logic [11:0]       speed,
	output logic              fall_s5,
	output logic [DIST_W-1:0] distance
);

	logic [57:0] prod_a;
	logic [26:0] q_s3;
	logic        fall_s3;
	logic [38:0] prod_s;
	logic [38:0] p_s4;
	logic        fall_s4;
	logic [17:0] hi;
	logic [35:0] prod_b;
	logic [15:0] qh;
	logic [17:0] rem_full;
	logic [15:0] qh_s5;
	logic [2:0]  rh_s5;
	logic [17:0] tl_s5;
	logic [20:0] lo;
	logic [41:0] prod_c;
	logic [33:0] quo;

	// Ticks to microseconds: divide by 8, then by 5.
	assign prod_a = 58'(width_in[31:3]) * 58'(RECIP_A);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3    <= prod_a[57:31];
			fall_s3 <= fall_in;
		end
	end

	assign prod_s = 39'(q_s3) * 39'(speed);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4    <= prod_s;
			fall_s4 <= fall_s3;
		end
	end

	// Divide by 40 in two digits: high half by 5, then remainder with low half.
	assign hi       = p_s4[38:21];
	assign prod_b   = 36'(hi) * 36'(RECIP_B);
	assign qh       = prod_b[35:20];
	assign rem_full = hi - 18'(qh * 3'd5);

	always_ff @(posedge clk) begin
		if (en) begin
			qh_s5   <= qh;
			rh_s5   <= rem_full[2:0];
			tl_s5   <= p_s4[20:3];
			fall_s5 <= fall_s4;
		end
	end

	assign lo     = {rh_s5, tl_s5};
	assign prod_c = 42'(lo) * 42'(RECIP_C);
	assign quo    = {qh_s5, prod_c[40:23]};

	// Saturate to the stored distance width.
	always_comb begin
		if (|quo[33:DIST_W]) begin
			distance = '1;
		end else begin
			distance = quo[DIST_W-1:0];
		end
	end

endmodule

### sv/ecr_checker.sv
module ecr_checker import ecr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);

	out_beat_t last_q;

	// Hold the last delivered result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (out_valid && out_ready) begin
			last_q <= out_data;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out_data changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held off with empty output");

	a_distance_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(out_data.updated_mask[0] || out_data.distance_zero == last_q.distance_zero) &&
			(out_data.updated_mask[1] || out_data.distance_one == last_q.distance_one) &&
			(out_data.updated_mask[2] || out_data.distance_two == last_q.distance_two) &&
			(out_data.updated_mask[3] || out_data.distance_three == last_q.distance_three))
		else $error("distance changed without its mask bit");

endmodule

bind multi_channel_echo_ranger ecr_checker u_ecr_checker (.*);
